// ===== hw/rtl/sdf_pkg.sv =====
// Package: shared types, constants and helpers of the signed decimal formatter.
`timescale 1ns / 1ps
package sdf_pkg;

    localparam int unsigned ValueW  = 32;
    localparam int unsigned Digits  = 10;
    localparam int unsigned BcdW    = 4 * Digits;
    localparam int unsigned StepW   = 5;
    localparam int unsigned NdigW   = 4;
    localparam int unsigned CharW   = 8;

    localparam logic [StepW-1:0] StepLast   = StepW'(ValueW - 1);
    localparam logic [NdigW-1:0] NdigFull   = NdigW'(Digits);
    localparam logic [NdigW-1:0] NdigOne    = NdigW'(1);
    localparam logic [CharW-1:0] CharZero   = 8'h30;
    localparam logic [CharW-1:0] CharMinus  = 8'h2D;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_SIGN,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture magnitude and sign, clear digits
        logic dabble;    // one shift-and-add-3 step
        logic shift;     // drop the top digit (leading zero or emitted)
        logic sel_sign;  // output shows the minus character
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic step_last; // final conversion step this cycle
        logic top_zero;  // top digit is zero
        logic one_left;  // one digit left in the window
        logic negative;  // value was negative
    } t_status;

    // Add 3 to every BCD digit of 5 or more, ahead of the left shift
    function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] bcd);
        logic [BcdW-1:0] res;
        res = bcd;
        for (int d = 0; d < Digits; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
                res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/sdf_if.sv =====
// Interfaces: input value channel and output character channel.
`timescale 1ns / 1ps
interface sdf_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [sdf_pkg::ValueW-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sdf_out_if;
    logic                       valid;
    logic                       ready;
    logic [sdf_pkg::CharW-1:0]  character;
    logic                       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hw/rtl/sdf_datapath.sv =====
// Datapath: magnitude shift register, double-dabble BCD register, character output.
`timescale 1ns / 1ps
module sdf_datapath (
    input  logic                              i_clk,
    input  logic signed [sdf_pkg::ValueW-1:0] i_value,
    input  sdf_pkg::t_cmd                     i_cmd,
    output sdf_pkg::t_status                  o_status,
    output logic [sdf_pkg::CharW-1:0]         o_character,
    output logic                              o_last
);

    logic [sdf_pkg::ValueW-1:0] r_mag, n_mag;
    logic [sdf_pkg::BcdW-1:0]   r_bcd, n_bcd;
    logic [sdf_pkg::StepW-1:0]  r_step, n_step;
    logic [sdf_pkg::NdigW-1:0]  r_ndig, n_ndig;
    logic                       r_neg, n_neg;
    logic [sdf_pkg::BcdW-1:0]   adj;
    logic [3:0]                 top_digit;

    assign adj       = sdf_pkg::bcd_adjust(r_bcd);
    assign top_digit = r_bcd[sdf_pkg::BcdW-1 -: 4];

    // Next values for the conversion registers
    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_step = r_step;
        n_ndig = r_ndig;
        n_neg  = r_neg;
        if (i_cmd.load) begin
            n_neg  = i_value[sdf_pkg::ValueW-1];
            n_mag  = n_neg ? (sdf_pkg::ValueW'(0) - sdf_pkg::ValueW'(i_value))
                           : sdf_pkg::ValueW'(i_value);
            n_bcd  = '0;
            n_step = '0;
            n_ndig = sdf_pkg::NdigFull;
        end else if (i_cmd.dabble) begin
            n_bcd  = {adj[sdf_pkg::BcdW-2:0], r_mag[sdf_pkg::ValueW-1]};
            n_mag  = {r_mag[sdf_pkg::ValueW-2:0], 1'b0};
            n_step = r_step + 1'b1;
        end else if (i_cmd.shift) begin
            n_bcd  = {r_bcd[sdf_pkg::BcdW-5:0], 4'd0};
            n_ndig = r_ndig - 1'b1;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_step <= n_step;
        r_ndig <= n_ndig;
        r_neg  <= n_neg;
    end

    // Status back to the controller
    assign o_status.step_last = (r_step == sdf_pkg::StepLast);
    assign o_status.top_zero  = (top_digit == 4'd0);
    assign o_status.one_left  = (r_ndig == sdf_pkg::NdigOne);
    assign o_status.negative  = r_neg;

    // Character shown on the output channel
    assign o_character = i_cmd.sel_sign ? sdf_pkg::CharMinus
                                        : (sdf_pkg::CharZero + {4'd0, top_digit});
    assign o_last      = !i_cmd.sel_sign && o_status.one_left;

endmodule

// ===== hw/rtl/sdf_controller.sv =====
// Controller: sequences load, conversion, leading-zero trim and character emission.
`timescale 1ns / 1ps
module sdf_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  sdf_pkg::t_status i_status,
    output sdf_pkg::t_cmd    o_cmd
);

    sdf_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            sdf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sdf_pkg::ST_CONVERT;
                end
            end
            sdf_pkg::ST_CONVERT: begin
                o_cmd.dabble = 1'b1;
                if (i_status.step_last) begin
                    n_state = sdf_pkg::ST_TRIM;
                end
            end
            sdf_pkg::ST_TRIM: begin
                // drop leading zeros, keeping at least one digit
                if (i_status.top_zero && !i_status.one_left) begin
                    o_cmd.shift = 1'b1;
                end else if (i_status.negative) begin
                    n_state = sdf_pkg::ST_SIGN;
                end else begin
                    n_state = sdf_pkg::ST_EMIT;
                end
            end
            sdf_pkg::ST_SIGN: begin
                o_cmd.sel_sign = 1'b1;
                o_out_valid    = 1'b1;
                if (i_out_ready) begin
                    n_state = sdf_pkg::ST_EMIT;
                end
            end
            sdf_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.one_left) begin
                        n_state = sdf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sdf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/signed_decimal_formatter_unit.sv =====
// Top level of the signed decimal formatter: controller plus datapath.
//
// Usage: one signed 32-bit value enters on i_in (valid/ready). The block
// sends its decimal text on o_out, one ASCII byte per transfer, most
// significant digit first: '-' for a negative value, no leading zeros,
// a single '0' for zero. last is high on the final character.
// Before the first character is offered, the block captures the value,
// runs the 32 shift-and-add-3 conversion steps through the BCD register,
// then drops each leading zero (up to 9) in the trim step.
// The block takes one value at a time; a new value is accepted only
// after the last character of the previous one has been taken.
// Input ready is high only while the block is idle.
// Reset (synchronous, active low) returns the controller to idle; any
// value in progress is dropped. When the receiver stalls, the current
// character holds on o_out until it is taken.
`timescale 1ns / 1ps
module signed_decimal_formatter_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sdf_in_if.sink           i_in,
    sdf_out_if.source        o_out
);

    sdf_pkg::t_cmd    cmd;
    sdf_pkg::t_status status;

    sdf_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sdf_datapath u_dp (
        .i_clk       (i_clk),
        .i_value     (i_in.value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_character (o_out.character),
        .o_last      (o_out.last)
    );

endmodule
